// ----- sv/assert_macros.svh -----
// assertion macros shared by the vertex transform rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HVT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hvt assertion failed");

// antecedent implies consequent in the following cycle
`define HVT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hvt assertion failed");

`endif

// ----- sv/hvt_pkg.sv -----
// types and constants of the homogeneous vertex transform
// no dependencies; imported by every module of the block
package hvt_pkg;

    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 12;
    localparam int COMP_W    = 32;
    localparam int PROD_W    = COEF_W + COMP_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int NUM_W     = COMP_W + 16;
    localparam int NCOLS     = 4;

    // pipeline depth: dot lane, divider prep, divider steps, output
    localparam int DOT_STAGES = 3;
    localparam int DIV_STAGES = NUM_W + 2;
    localparam int PIPE_DEPTH = DOT_STAGES + DIV_STAGES;

    localparam logic signed [31:0] Q_ONE   = 32'sd65536;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // register indexes
    localparam logic [1:0] REG_ROW0 = 2'd0;
    localparam logic [1:0] REG_ROW1 = 2'd1;
    localparam logic [1:0] REG_ROW2 = 2'd2;
    localparam logic [1:0] REG_ROW3 = 2'd3;

    // identity matrix at reset
    localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_1000;
    localparam logic [63:0] ROW1_RST = 64'h0000_0000_1000_0000;
    localparam logic [63:0] ROW2_RST = 64'h0000_1000_0000_0000;
    localparam logic [63:0] ROW3_RST = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
    } t_vtx_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               divided;
    } t_vtx_out;

endpackage

// ----- sv/hvt_dot_lane.sv -----
// one matrix row times the vertex: multiply, add, floor shift and saturate
// depends on hvt_pkg
module hvt_dot_lane
    import hvt_pkg::*;
(
    input  logic                      i_clk,
    input  logic [DOT_STAGES-1:0]     i_en,
    input  logic [63:0]               i_row,
    input  t_vtx_in                   i_vtx,
    output logic signed [COMP_W-1:0]  o_row
);

    logic signed [COMP_W-1:0] comp [NCOLS];
    logic signed [PROD_W-1:0] n_prod [NCOLS];
    logic signed [PROD_W-1:0] r_prod [NCOLS];
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  shifted;
    logic signed [COMP_W-1:0] n_row;

    assign comp[0] = i_vtx.in_x;
    assign comp[1] = i_vtx.in_y;
    assign comp[2] = i_vtx.in_z;
    assign comp[3] = i_vtx.in_w;

    // four 16x32 products, one multiplier per column
    always_comb begin
        for (int c = 0; c < NCOLS; c++) begin
            n_prod[c] = PROD_W'($signed(i_row[COEF_W*c +: COEF_W])) * PROD_W'(comp[c]);
        end
    end

    // exact sum of the products
    assign n_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1])
                 + SUM_W'(r_prod[2]) + SUM_W'(r_prod[3]);

    // arithmetic shift floors, then clamp to 32 bits
    always_comb begin
        shifted = r_sum >>> COEF_FRAC;
        if (shifted[SUM_W-1:COMP_W-1] == {(SUM_W-COMP_W+1){shifted[COMP_W-1]}}) begin
            n_row = shifted[COMP_W-1:0];
        end else if (shifted[SUM_W-1]) begin
            n_row = S32_MIN;
        end else begin
            n_row = S32_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= n_prod;
        end
        if (i_en[1]) begin
            r_sum <= n_sum;
        end
        if (i_en[2]) begin
            o_row <= n_row;
        end
    end

endmodule

// ----- sv/hvt_div_lane.sv -----
// pipelined signed division, one quotient bit per stage, with saturation
// depends on hvt_pkg
module hvt_div_lane
    import hvt_pkg::*;
(
    input  logic                      i_clk,
    input  logic [DIV_STAGES-1:0]     i_en,
    input  logic signed [NUM_W-1:0]   i_num,
    input  logic signed [COMP_W-1:0]  i_den,
    output logic signed [COMP_W-1:0]  o_q
);

    logic [COMP_W-1:0] r_rem [NUM_W+1];
    logic [NUM_W-1:0]  r_nq  [NUM_W+1];
    logic [COMP_W-1:0] r_ad  [NUM_W+1];
    logic              r_neg [NUM_W+1];
    logic [NUM_W-1:0]  q;
    logic signed [COMP_W-1:0] n_q;

    // prep: magnitudes and result sign
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= '0;
            r_nq[0]  <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_ad[0]  <= i_den[COMP_W-1] ? COMP_W'(-i_den) : COMP_W'(i_den);
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[COMP_W-1];
        end
    end

    // restoring steps
    for (genvar s = 1; s <= NUM_W; s++) begin : g_step
        logic [COMP_W:0] trial;
        logic [COMP_W:0] diff;
        logic            ge;
        assign trial = {r_rem[s-1], r_nq[s-1][NUM_W-1]};
        assign diff  = trial - {1'b0, r_ad[s-1]};
        assign ge    = (trial >= {1'b0, r_ad[s-1]});
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= ge ? diff[COMP_W-1:0] : trial[COMP_W-1:0];
                r_nq[s]  <= {r_nq[s-1][NUM_W-2:0], ge};
                r_ad[s]  <= r_ad[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end
    end

    // sign and saturation of the quotient
    assign q = r_nq[NUM_W];
    always_comb begin
        if (!r_neg[NUM_W]) begin
            n_q = (q > NUM_W'(S32_MAX)) ? S32_MAX : q[COMP_W-1:0];
        end else if (q > {{(NUM_W-COMP_W){1'b0}}, S32_MIN}) begin
            n_q = S32_MIN;
        end else begin
            n_q = COMP_W'(-q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[DIV_STAGES-1]) begin
            o_q <= n_q;
        end
    end

endmodule

// ----- sv/homogeneous_vertex_transform.sv -----
// top level of the homogeneous vertex transform: registers, lanes, merge
// depends on hvt_pkg, hvt_dot_lane, hvt_div_lane and assert_macros.svh
//
// usage
//   input channel: i_vtx with i_valid; the block drives o_stall. a vertex is
//   taken at an edge where i_valid is high and o_stall is low.
//   output channel: o_vtx with o_valid; the receiver drives i_stall. a result
//   leaves at an edge where o_valid is high and i_stall is low.
//   four dot-product lanes work on the rows side by side; three divider lanes
//   then divide x, y, z by w one quotient bit per stage (48 stages).
//   53 stages in all: dot-lane, divider-prep, divider-step and output stages.
//   throughput is one vertex per cycle, set by the fully pipelined lanes, while
//   i_stall is low. when the receiver stalls, stages fill up from the output
//   backward and bubbles are squeezed out; o_stall rises only once every stage
//   holds data. reset empties the pipeline and loads the identity matrix into
//   the row registers. rows are to be written over the apb port only while
//   the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"
module homogeneous_vertex_transform
    import hvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_vtx_in     i_vtx,
    output logic        o_valid,
    input  logic        i_stall,
    output t_vtx_out    o_vtx,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] r_row [NCOLS];
    logic [PIPE_DEPTH-1:0] r_valid;
    logic [PIPE_DEPTH-1:0] w_en;
    logic signed [COMP_W-1:0] row_val [NCOLS];
    logic signed [COMP_W-1:0] quot [3];
    logic [DIV_STAGES-1:0] r_flag;
    logic w_zero;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];

    // row registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW0_RST;
            r_row[1] <= ROW1_RST;
            r_row[2] <= ROW2_RST;
            r_row[3] <= ROW3_RST;
        end else if (psel && penable && pwrite) begin
            r_row[reg_idx] <= pwdata;
        end
    end

    // read decode
    always_comb begin
        unique case (reg_idx)
            REG_ROW0: prdata = r_row[0];
            REG_ROW1: prdata = r_row[1];
            REG_ROW2: prdata = r_row[2];
            REG_ROW3: prdata = r_row[3];
            default:  prdata = '0;
        endcase
    end

    // stage enables: a stage moves when empty or when the next one moves
    assign w_en[PIPE_DEPTH-1] = !r_valid[PIPE_DEPTH-1] || !i_stall;
    for (genvar k = 0; k < PIPE_DEPTH-1; k++) begin : g_en
        assign w_en[k] = !r_valid[k] || w_en[k+1];
    end
    assign o_stall = !w_en[0];
    assign o_valid = r_valid[PIPE_DEPTH-1];

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // row lanes
    for (genvar r = 0; r < NCOLS; r++) begin : g_dot
        hvt_dot_lane u_dot (
            .i_clk (i_clk),
            .i_en  (w_en[DOT_STAGES-1:0]),
            .i_row (r_row[r]),
            .i_vtx (i_vtx),
            .o_row (row_val[r])
        );
    end

    // zero w: divide the raw value by one so it passes unchanged
    assign w_zero = (row_val[3] == '0);
    for (genvar d = 0; d < 3; d++) begin : g_div
        hvt_div_lane u_div (
            .i_clk (i_clk),
            .i_en  (w_en[PIPE_DEPTH-1:DOT_STAGES]),
            .i_num (w_zero ? NUM_W'(row_val[d]) : {row_val[d], 16'b0}),
            .i_den (w_zero ? 32'sd1 : row_val[3]),
            .o_q   (quot[d])
        );
    end

    // divided flag rides along the divider stages
    always_ff @(posedge i_clk) begin
        if (w_en[DOT_STAGES]) begin
            r_flag[0] <= !w_zero;
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (w_en[DOT_STAGES+k]) begin
                r_flag[k] <= r_flag[k-1];
            end
        end
    end

    // merge
    assign o_vtx.out_x   = quot[0];
    assign o_vtx.out_y   = quot[1];
    assign o_vtx.out_z   = quot[2];
    assign o_vtx.divided = r_flag[DIV_STAGES-1];
    assign o_vtx.out_w   = r_flag[DIV_STAGES-1] ? Q_ONE : '0;

    `HVT_ASSERT_IMP(a_empty_takes, i_clk, i_rst_n, !r_valid[0], !o_stall)
    `HVT_ASSERT_NXT(a_accept_fills, i_clk, i_rst_n, i_valid && !o_stall, r_valid[0])
    `HVT_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid)

endmodule
